@@ hw/rtl/bst_pkg.sv @@
// Package for the binary search table: field widths, defaults, codes
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package bst_pkg;

  // Default sizing handed to the top level
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BYTES_DEF   = 4;

  // Fixed payload widths
  localparam int MODE_W   = 1;
  localparam int INDEX_W  = 10;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 10;
  localparam int PROBES_W = 4;
  localparam int SIZE_W   = 11;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TABLE_SIZE = 1'b0;  // word index of table_size

  // Request modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Search sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } bst_state_t;

endpackage

@@ hw/rtl/bst_in_if.sv @@
// Request channel of the binary search table: valid/ready plus payload.
// Depends on bst_pkg for field widths.
`timescale 1ns / 1ps

interface bst_in_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::MODE_W-1:0]    mode;
  logic [bst_pkg::INDEX_W-1:0]   index;
  logic [bst_pkg::KEY_W-1:0]     key;

  modport source (output valid, mode, index, key, input ready);
  modport sink   (input valid, mode, index, key, output ready);
endinterface

@@ hw/rtl/bst_out_if.sv @@
// Result channel of the binary search table: valid/ready plus payload.
// Depends on bst_pkg for field widths.
`timescale 1ns / 1ps

interface bst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [bst_pkg::POS_W-1:0]     position;
  logic [bst_pkg::PROBES_W-1:0]  probes;

  modport source (output valid, found, position, probes, input ready);
  modport sink   (input valid, found, position, probes, output ready);
endinterface

@@ hw/rtl/binary_search_table.sv @@
// Binary search table. A load request writes one key and gives no result.
// A search request takes, per probe, one RAM read state and one compare state,
// then a done state hands the result to the output register once it is free.
// The single RAM read port means that each probe needs its own read.
// Reset (synchronous, rst_n low) clears table_size, the sequencer and the
// output valid; the key table itself is not cleared.
`timescale 1ns / 1ps

module binary_search_table #(
  parameter int TABLE_DEPTH = bst_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = bst_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bst_in_if.sink                         in_ch,
  bst_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bst_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bst_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bst_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  // Derived widths
  localparam int AW = $clog2(TABLE_DEPTH);                 // table address
  localparam int CW = AW + 1;                              // range bounds
  localparam int KW = 8 * KEY_BYTES;                       // stored key
  localparam int XW = (KW > bst_pkg::KEY_W) ? KW : bst_pkg::KEY_W;
  localparam int IW = (CW > bst_pkg::INDEX_W) ? CW : bst_pkg::INDEX_W;
  localparam int SW = (CW > bst_pkg::SIZE_W) ? CW : bst_pkg::SIZE_W;
  localparam int PW = (CW > bst_pkg::POS_W) ? CW : bst_pkg::POS_W;

  // Registers
  bst_pkg::bst_state_t            state_r, state_nxt;
  logic [bst_pkg::SIZE_W-1:0]     table_size_r;
  logic [CW-1:0]                  lo_r, lo_nxt;
  logic [CW-1:0]                  hi_r, hi_nxt;     // exclusive upper bound
  logic [KW-1:0]                  key_r, key_nxt;
  logic                           found_r, found_nxt;
  logic [bst_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [bst_pkg::PROBES_W-1:0]   probes_r, probes_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [bst_pkg::POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [bst_pkg::PROBES_W-1:0]   out_probes_r, out_probes_nxt;

  // Combinational helpers
  logic                           in_acc;
  logic [IW-1:0]                  idx_wide;
  logic [XW-1:0]                  key_wide;
  logic [KW-1:0]                  key_in;
  logic [SW-1:0]                  size_ext;
  logic [SW-1:0]                  depth_ext;
  logic [SW-1:0]                  n_ext;
  logic [CW-1:0]                  span;
  logic [CW-1:0]                  mid;
  logic [PW-1:0]                  mid_wide;
  logic [KW-1:0]                  entry;
  logic                           ram_we;
  logic                           cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_wr && (paddr[2] == bst_pkg::REG_TABLE_SIZE)) begin
      table_size_r <= pwdata[bst_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == bst_pkg::REG_TABLE_SIZE) begin
      prdata = bst_pkg::CFG_DATA_W'(table_size_r);
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Request decode
  assign in_ch.ready = (state_r == bst_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign idx_wide    = IW'(in_ch.index);
  assign key_wide    = XW'(in_ch.key);
  assign key_in      = key_wide[KW-1:0];

  // loads beyond the table are dropped
  assign ram_we = in_acc && (in_ch.mode == bst_pkg::MODE_LOAD) &&
                  (idx_wide < IW'(TABLE_DEPTH));

  // entries searched: table_size clipped to the depth
  assign size_ext  = SW'(table_size_r);
  assign depth_ext = SW'(TABLE_DEPTH);
  assign n_ext     = (size_ext > depth_ext) ? depth_ext : size_ext;

  // probe point of the current range
  assign span     = hi_r - lo_r - CW'(1);
  assign mid      = lo_r + (span >> 1);
  assign mid_wide = PW'(mid);

  // ---------------------------------------------------------------------
  // Key table
  bst_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_wide[AW-1:0]),
    .wdata (key_in),
    .raddr (mid[AW-1:0]),
    .rdata (entry)
  );

  // ---------------------------------------------------------------------
  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    key_r        <= key_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    probes_r     <= probes_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_probes_r <= out_probes_nxt;
  end

  // Next state: start, probe read, compare and narrow, hand over
  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    probes_nxt     = probes_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_probes_nxt = out_probes_r;

    unique case (state_r)
      bst_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.mode == bst_pkg::MODE_SEARCH)) begin
          lo_nxt     = '0;
          hi_nxt     = n_ext[CW-1:0];
          key_nxt    = key_in;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          probes_nxt = '0;
          if (n_ext == '0) begin
            state_nxt = bst_pkg::ST_DONE;
          end else begin
            state_nxt = bst_pkg::ST_READ;
          end
        end
      end
      bst_pkg::ST_READ: begin
        // RAM address is mid; data arrives next cycle
        state_nxt = bst_pkg::ST_CMP;
      end
      bst_pkg::ST_CMP: begin
        if (probes_r != '1) begin
          probes_nxt = probes_r + bst_pkg::PROBES_W'(1);
        end
        if (entry == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_wide[bst_pkg::POS_W-1:0];
          state_nxt = bst_pkg::ST_DONE;
        end else begin
          if (entry > key_r) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + CW'(1);
          end
          if (lo_nxt < hi_nxt) begin
            state_nxt = bst_pkg::ST_READ;
          end else begin
            state_nxt = bst_pkg::ST_DONE;
          end
        end
      end
      bst_pkg::ST_DONE: begin
        // move the result into the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_pos_nxt    = pos_r;
          out_probes_nxt = probes_r;
          state_nxt      = bst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bst_pkg::ST_IDLE;
      end
    endcase
  end

  // Result channel
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.probes   = out_probes_r;

`ifndef SYNTHESIS
  // a probe is only issued on a non-empty range
  a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bst_pkg::ST_CMP) |-> (lo_r < hi_r))
    else $error("probe on empty search range");

  // a hit needs at least one compare
  a_hit_probed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_probes_r != '0))
    else $error("hit reported with no probe");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_pos_r == '0))
    else $error("miss reported with non-zero position");

  // a search holds off further requests until it has finished
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.mode == bst_pkg::MODE_SEARCH)) |=> !in_ch.ready)
    else $error("request taken while a search is running");
`endif

endmodule

@@ hw/rtl/bst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
